>>> design/svig_pkg.sv
// ----------------------------------------------------------------------------
// svig_pkg
// shared types and constants of the shadow volume index generator
// ----------------------------------------------------------------------------
package svig_pkg;

   localparam int MAX_FACES = 1024;
   localparam int FACE_W    = $clog2(MAX_FACES);
   localparam int IDX_W     = 16;
   localparam int VEC_W     = 16;
   localparam int CMD_W     = 3;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W    = 2 * VEC_W + 1;
   localparam int ACC_W     = PROD_W + 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_STORE     = 3'd0,
      CMD_CLASSIFY  = 3'd1,
      CMD_DARK_CAP  = 3'd2,
      CMD_LIGHT_CAP = 3'd3,
      CMD_EDGE      = 3'd4
   } cmd_type;

   localparam logic [1:0] REG_LIGHT_KIND = 2'd0;
   localparam logic [1:0] REG_LIGHT_X    = 2'd1;
   localparam logic [1:0] REG_LIGHT_Y    = 2'd2;
   localparam logic [1:0] REG_LIGHT_Z    = 2'd3;

   typedef struct packed {
      logic capture;
      logic read;
      logic write_normal;
      logic clear_we;
      logic mac;
      logic write_lit;
      logic emit_load;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             clear_last;
      logic             mac_last;
      logic             emit_any;
      logic             emit_last;
      logic             out_free;
   } status_type;

endpackage

>>> design/svig_csr.sv
// ----------------------------------------------------------------------------
// svig_csr
// light configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module svig_csr
   import svig_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready,
   output logic                         light_kind,
   output logic signed [VEC_W-1:0]      light_x,
   output logic signed [VEC_W-1:0]      light_y,
   output logic signed [VEC_W-1:0]      light_z
);

   logic                    kind_ff, kind_in;
   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                    wr_en;
   logic [1:0]              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      kind_in = kind_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LIGHT_KIND: kind_in = csr_pwdata[0];
            REG_LIGHT_X:    x_in    = csr_pwdata[VEC_W-1:0];
            REG_LIGHT_Y:    y_in    = csr_pwdata[VEC_W-1:0];
            REG_LIGHT_Z:    z_in    = csr_pwdata[VEC_W-1:0];
            default:        kind_in = kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
      end else begin
         kind_ff <= kind_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LIGHT_KIND: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, kind_ff};
         REG_LIGHT_X:    csr_prdata = {{(CSR_DATA_W-VEC_W){1'b0}}, x_ff};
         REG_LIGHT_Y:    csr_prdata = {{(CSR_DATA_W-VEC_W){1'b0}}, y_ff};
         REG_LIGHT_Z:    csr_prdata = {{(CSR_DATA_W-VEC_W){1'b0}}, z_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign light_kind = kind_ff;
   assign light_x    = x_ff;
   assign light_y    = y_ff;
   assign light_z    = z_ff;

endmodule

>>> design/svig_ctrl.sv
// ----------------------------------------------------------------------------
// svig_ctrl
// sequencer: lit store clearing, item capture, classify and emission steps
// ----------------------------------------------------------------------------
module svig_ctrl
   import svig_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output ctrl_type   ctrl
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_MAC   = 7'b0001000,
      S_LIT   = 7'b0010000,
      S_EVAL  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctrl.clear_we = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            ctrl.read = 1'b1;
            case (status.cmd)
               CMD_STORE: begin
                  ctrl.write_normal = 1'b1;
                  state_in          = S_IDLE;
               end
               CMD_CLASSIFY:                      state_in = S_MAC;
               CMD_DARK_CAP, CMD_LIGHT_CAP, CMD_EDGE: state_in = S_EVAL;
               default:                           state_in = S_IDLE;
            endcase
         end
         S_MAC: begin
            ctrl.mac = 1'b1;
            if (status.mac_last) state_in = S_LIT;
         end
         S_LIT: begin
            ctrl.write_lit = 1'b1;
            state_in       = S_IDLE;
         end
         S_EVAL: begin
            state_in = status.emit_any ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.out_free) begin
               ctrl.emit_load = 1'b1;
               if (status.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/svig_dp.sv
// ----------------------------------------------------------------------------
// svig_dp
// datapath: item registers, normal and lit stores, dot product unit and
// output register
// ----------------------------------------------------------------------------
module svig_dp
   import svig_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic [CMD_W-1:0]        req_tuser,
   input  logic                    light_kind,
   input  logic signed [VEC_W-1:0] light_x,
   input  logic signed [VEC_W-1:0] light_y,
   input  logic signed [VEC_W-1:0] light_z,
   input  ctrl_type                ctrl,
   output status_type              status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   output logic                    rsp_tlast
);

   // item registers
   logic [CMD_W-1:0]        cmd_ff;
   logic [FACE_W-1:0]       f0_ff, f1_ff;
   logic                    v0_ff, v1_ff;
   logic [IDX_W-1:0]        a_ff, b_ff, c_ff;
   logic signed [VEC_W-1:0] vx_ff, vy_ff, vz_ff;

   // stores
   logic [3*VEC_W-1:0]      normal_mem [MAX_FACES];
   logic                    lit_mem    [MAX_FACES];
   logic [3*VEC_W-1:0]      normal_rd_ff;
   logic                    lit0_rd_ff, lit1_rd_ff;
   logic [FACE_W-1:0]       clr_cnt_ff, clr_cnt_in;

   // dot product
   logic signed [VEC_W:0]   dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [1:0]              step_ff, step_in;
   logic signed [VEC_W-1:0] mul_n;
   logic signed [VEC_W:0]   mul_d;
   logic signed [PROD_W-1:0] mul_out, prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // emission
   logic [2:0]              emit_cnt_ff, emit_cnt_in;
   logic                    emit_any, quad, lit_sel, cap_inc;
   logic [2:0]              emit_n;
   logic [IDX_W-1:0]        p_val, q_val, emit_val;
   logic                    out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]        out_idx_ff;
   logic                    out_last_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_tuser;
         f0_ff  <= req_tdata[9:0];
         f1_ff  <= req_tdata[19:10];
         v0_ff  <= req_tdata[20];
         v1_ff  <= req_tdata[21];
         a_ff   <= req_tdata[37:22];
         b_ff   <= req_tdata[53:38];
         c_ff   <= req_tdata[69:54];
         vx_ff  <= req_tdata[85:70];
         vy_ff  <= req_tdata[101:86];
         vz_ff  <= req_tdata[117:102];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_normal) begin
         normal_mem[f0_ff] <= {vz_ff, vy_ff, vx_ff};
      end
      if (ctrl.read) begin
         normal_rd_ff <= normal_mem[f0_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear_we) begin
         lit_mem[clr_cnt_ff] <= 1'b0;
      end else if (ctrl.write_lit) begin
         lit_mem[f0_ff] <= (acc_ff > ACC_W'(0));
      end
      if (ctrl.read) begin
         lit0_rd_ff <= lit_mem[f0_ff];
         lit1_rd_ff <= lit_mem[f1_ff];
      end
   end

   assign clr_cnt_in        = ctrl.clear_we ? clr_cnt_ff + FACE_W'(1) : clr_cnt_ff;
   assign status.clear_last = (clr_cnt_ff == FACE_W'(MAX_FACES - 1));

   // light vector, point minus position for a point light
   always_comb begin
      if (light_kind) begin
         dx_in = (VEC_W+1)'(vx_ff) - (VEC_W+1)'(light_x);
         dy_in = (VEC_W+1)'(vy_ff) - (VEC_W+1)'(light_y);
         dz_in = (VEC_W+1)'(vz_ff) - (VEC_W+1)'(light_z);
      end else begin
         dx_in = (VEC_W+1)'(light_x);
         dy_in = (VEC_W+1)'(light_y);
         dz_in = (VEC_W+1)'(light_z);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.read) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_n = normal_rd_ff[VEC_W-1:0];
            mul_d = dx_ff;
         end
         2'd1: begin
            mul_n = normal_rd_ff[2*VEC_W-1:VEC_W];
            mul_d = dy_ff;
         end
         default: begin
            mul_n = normal_rd_ff[3*VEC_W-1:2*VEC_W];
            mul_d = dz_ff;
         end
      endcase
   end

   assign mul_out = mul_n * mul_d;
   assign acc_in  = (step_ff == 2'd0) ? '0 : acc_ff + ACC_W'(prod_ff);
   assign step_in = ctrl.mac ? step_ff + 2'd1 : step_ff;
   assign status.mac_last = (step_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (ctrl.mac) begin
         prod_ff <= mul_out;
         acc_ff  <= acc_in;
      end
   end

   // which face decides, and whether anything is emitted
   always_comb begin
      emit_any = 1'b0;
      quad     = 1'b0;
      lit_sel  = lit0_rd_ff;
      cap_inc  = 1'b0;
      case (cmd_ff)
         CMD_DARK_CAP:  emit_any = lit0_rd_ff;
         CMD_LIGHT_CAP: begin
            emit_any = !lit0_rd_ff;
            cap_inc  = 1'b1;
         end
         CMD_EDGE: begin
            quad = 1'b1;
            if (v0_ff && v1_ff) begin
               emit_any = (lit0_rd_ff != lit1_rd_ff);
            end else if (v0_ff) begin
               emit_any = 1'b1;
            end else if (v1_ff) begin
               emit_any = 1'b1;
               lit_sel  = lit1_rd_ff;
            end
         end
         default: emit_any = 1'b0;
      endcase
   end

   assign p_val  = lit_sel ? a_ff : b_ff;
   assign q_val  = lit_sel ? b_ff : a_ff;
   assign emit_n = quad ? 3'd6 : 3'd3;

   always_comb begin
      if (quad) begin
         case (emit_cnt_ff)
            3'd0:    emit_val = p_val;
            3'd1:    emit_val = q_val;
            3'd2:    emit_val = p_val + IDX_W'(1);
            3'd3:    emit_val = q_val;
            3'd4:    emit_val = q_val + IDX_W'(1);
            default: emit_val = p_val + IDX_W'(1);
         endcase
      end else begin
         case (emit_cnt_ff)
            3'd0:    emit_val = a_ff + IDX_W'(cap_inc);
            3'd1:    emit_val = c_ff + IDX_W'(cap_inc);
            default: emit_val = b_ff + IDX_W'(cap_inc);
         endcase
      end
   end

   assign status.emit_any  = emit_any;
   assign status.emit_last = (emit_cnt_ff == emit_n - 3'd1);
   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.cmd       = cmd_ff;

   always_comb begin
      emit_cnt_in = emit_cnt_ff;
      if (ctrl.emit_load) begin
         emit_cnt_in = status.emit_last ? 3'd0 : emit_cnt_ff + 3'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.emit_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_load) begin
         out_idx_ff  <= emit_val;
         out_last_ff <= status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         step_ff      <= '0;
         emit_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         step_ff      <= step_in;
         emit_cnt_ff  <= emit_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_idx_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> design/shadow_volume_index_generator_core.sv
// ----------------------------------------------------------------------------
// shadow_volume_index_generator_core
// per-face lit classification and silhouette / cap index emission
//
// req channel: one command per transaction, kind on req_tuser; store normal,
//    classify face, dark cap, light cap or edge
// rsp channel: one shadow volume vertex index per transaction, rsp_tlast on
//    the final index of a command
// csr port: light kind and light vector x, y, z at byte addresses 0, 4, 8, 12
// one command at a time; req_tready is high only while the sequencer is idle
// classify uses one shared 16x17 multiplier over the three components, then
//    accumulates; a cap emits 3 results or none, an edge 6 results or none,
//    and undefined commands emit nothing
// a cap or edge is read in S_READ and evaluated in S_EVAL, and its first
//    index is loaded into the output register in S_EMIT
// the output register lets the next command be accepted while the last
//    index still waits; a stalled receiver holds further emission
// after reset a clearing pass marks all faces unlit; no command is accepted
//    until it ends
// ----------------------------------------------------------------------------
module shadow_volume_index_generator_core
   import svig_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // face_first, face_second, first_valid, second_valid, vert_a, vert_b,
   // vert_c, vec_x, vec_y, vec_z, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vertex_index
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic                    light_kind;
   logic signed [VEC_W-1:0] light_x, light_y, light_z;
   ctrl_type                ctrl;
   status_type              status;

   svig_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .light_kind  (light_kind),
      .light_x     (light_x),
      .light_y     (light_y),
      .light_z     (light_z)
   );

   svig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   svig_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .light_kind (light_kind),
      .light_x    (light_x),
      .light_y    (light_y),
      .light_z    (light_z),
      .ctrl       (ctrl),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
